### rtl/orbit_camera_look_at_assert.svh
// assertion macros for the orbit camera look-at block
`ifndef ORBIT_CAMERA_LOOK_AT_ASSERT_SVH
`define ORBIT_CAMERA_LOOK_AT_ASSERT_SVH
`ifndef ASSERT_OFF
`define OCL_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("orbit camera assertion failed");
`define OCL_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("orbit camera forbidden condition");
`else
`define OCL_ASSERT(label, prop)
`define OCL_NEVER(label, expr)
`endif
`endif

### rtl/ocl_pkg.sv
// shared types, constants and helper functions of the orbit camera block
`timescale 1ns / 1ps
package ocl_pkg;
	localparam int FULL_TURN    = 23040;
	localparam int HALF_TURN    = 11520;
	localparam int QUARTER_TURN = 5760;
	localparam int ATAN_COUNT   = 24;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] ATAN_TAB [ATAN_COUNT] = '{
		32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
		32'sd3750058, 32'sd1876857, 32'sd938658, 32'sd469357,
		32'sd234682, 32'sd117342, 32'sd58671, 32'sd29335,
		32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
		32'sd917, 32'sd458, 32'sd229, 32'sd115,
		32'sd57, 32'sd29, 32'sd14, 32'sd7
	};

	typedef logic signed [33:0] q30_t;

	typedef struct packed {
		q30_t               x;
		q30_t               y;
		logic signed [31:0] z;
		logic               neg;
	} lane_t;

	typedef struct packed {
		logic signed [31:0] left;
		logic signed [31:0] top;
		logic [23:0]        width;
		logic [23:0]        height;
		logic [23:0]        orbit_dist;
		logic               right_neg;
		logic               bad;
	} side_t;

	typedef struct packed {
		lane_t yaw;
		lane_t pitch;
		side_t side;
	} cord_t;

	typedef struct packed {
		q30_t  cy;
		q30_t  sy;
		q30_t  cp;
		q30_t  sp;
		side_t side;
	} trig_t;

	// angle modulo one full turn, result in [0, FULL_TURN)
	function automatic logic [14:0] reduce_angle(logic signed [15:0] a);
		logic signed [16:0] t;
		t = {a[15], a};
		if (t < 0) t = t + 17'sd23040;
		if (t < 0) t = t + 17'sd23040;
		if (t >= 17'sd23040) t = t - 17'sd23040;
		return t[14:0];
	endfunction

	// fold into +-quarter turn and seed the cordic lane
	function automatic lane_t fold_angle(logic [14:0] r);
		logic signed [16:0] t;
		lane_t l;
		t = {2'b00, r};
		l.neg = 1'b0;
		if (t > 17'sd11520) t = t - 17'sd23040;
		if (t > 17'sd5760) begin
			t = t - 17'sd11520;
			l.neg = 1'b1;
		end else if (t < -17'sd5760) begin
			t = t + 17'sd11520;
			l.neg = 1'b1;
		end
		l.x = CORDIC_GAIN;
		l.y = '0;
		l.z = {{15{t[16]}}, t} <<< 14;
		return l;
	endfunction

	function automatic lane_t cordic_iter(lane_t a, int i);
		lane_t b;
		b = a;
		if (!a.z[31]) begin
			b.x = a.x - (a.y >>> i);
			b.y = a.y + (a.x >>> i);
			b.z = a.z - ATAN_TAB[i];
		end else begin
			b.x = a.x + (a.y >>> i);
			b.y = a.y - (a.x >>> i);
			b.z = a.z + ATAN_TAB[i];
		end
		return b;
	endfunction
endpackage

### rtl/ocl_cordic.sv
// pipelined rotation cordic, yaw and pitch lanes side by side
`timescale 1ns / 1ps
module ocl_cordic #(
	parameter int STEPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ocl_pkg::cord_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ocl_pkg::trig_t out_data
);
	import ocl_pkg::*;

	cord_t data_s [0:STEPS];
	logic  vld_s  [0:STEPS];
	logic  en     [0:STEPS];

	assign data_s[0] = in_data;
	assign vld_s[0]  = in_valid;
	assign en[STEPS] = out_ready;
	assign in_ready  = en[0];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		// a stage loads when empty or when its content moves on
		assign en[i] = !vld_s[i+1] || en[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en[i]) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				data_s[i+1].yaw   <= cordic_iter(data_s[i].yaw, i);
				data_s[i+1].pitch <= cordic_iter(data_s[i].pitch, i);
				data_s[i+1].side  <= data_s[i].side;
			end
		end
	end

	assign out_valid = vld_s[STEPS];

	always_comb begin
		out_data.cy   = data_s[STEPS].yaw.neg   ? -data_s[STEPS].yaw.x   : data_s[STEPS].yaw.x;
		out_data.sy   = data_s[STEPS].yaw.neg   ? -data_s[STEPS].yaw.y   : data_s[STEPS].yaw.y;
		out_data.cp   = data_s[STEPS].pitch.neg ? -data_s[STEPS].pitch.x : data_s[STEPS].pitch.x;
		out_data.sp   = data_s[STEPS].pitch.neg ? -data_s[STEPS].pitch.y : data_s[STEPS].pitch.y;
		out_data.side = data_s[STEPS].side;
	end
endmodule

### rtl/ocl_vecmath.sv
// product, rounding and saturation stages that build the camera matrix
`timescale 1ns / 1ps
module ocl_vecmath #(
	parameter int UNIT_FRAC = 14
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ocl_pkg::trig_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z,
	output logic signed [15:0] back_x,
	output logic signed [15:0] back_y,
	output logic signed [15:0] back_z,
	output logic signed [31:0] eye_x,
	output logic signed [31:0] eye_y,
	output logic signed [31:0] eye_z,
	output logic               valid_res
);
	import ocl_pkg::*;

	localparam int USH = 30 - UNIT_FRAC;
	localparam logic signed [71:0] UHALF = 72'sd1 <<< (USH - 1);
	localparam logic signed [71:0] ULIM  = 72'sd1 <<< UNIT_FRAC;
	localparam logic signed [71:0] HALF30 = 72'sd1 <<< 29;

	function automatic logic signed [15:0] unit_out(logic signed [71:0] v);
		logic signed [71:0] q;
		q = (v + UHALF) >>> USH;
		if (q > ULIM) q = ULIM;
		if (q < -ULIM) q = -ULIM;
		if (q > 72'sd32767) q = 72'sd32767;
		if (q < -72'sd32768) q = -72'sd32768;
		return q[15:0];
	endfunction

	function automatic logic signed [71:0] rnd30(logic signed [71:0] v);
		return (v + HALF30) >>> 30;
	endfunction

	function automatic logic signed [31:0] eye_out(logic signed [71:0] v);
		logic signed [71:0] q;
		q = (v + HALF30) >>> 30;
		if (q > 72'sd2147483647) q = 72'sd2147483647;
		if (q < -72'sd2147483648) q = -72'sd2147483648;
		return q[31:0];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	// stage 1: back x/z products, right axis
	logic signed [71:0] pbx_s1, pbz_s1;
	q30_t rx_s1, rz_s1, by_s1;
	side_t side_s1;
	// stage 2: rounded back, target centre
	q30_t rx_s2, rz_s2, by_s2;
	logic signed [35:0] bx_s2, bz_s2;
	logic signed [33:0] cx_s2, cy_s2;
	logic [23:0] d_s2;
	logic bad_s2;
	// stage 3: up and eye products
	logic signed [71:0] ux_s3, uya_s3, uyb_s3, uz_s3, ex_s3, ey_s3, ez_s3;
	logic signed [71:0] rx_s3, rz_s3, bx_s3, by_s3, bz_s3;
	logic signed [33:0] cx_s3, cy_s3;
	logic bad_s3;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pbx_s1  <= 72'(in_data.sy * in_data.cp);
			pbz_s1  <= 72'(in_data.cy * in_data.cp);
			rx_s1   <= in_data.side.right_neg ? -in_data.cy : in_data.cy;
			rz_s1   <= in_data.side.right_neg ? in_data.sy : -in_data.sy;
			by_s1   <= in_data.sp;
			side_s1 <= in_data.side;
		end
		if (en2) begin
			bx_s2  <= 36'(rnd30(pbx_s1));
			bz_s2  <= 36'(rnd30(pbz_s1));
			rx_s2  <= rx_s1;
			rz_s2  <= rz_s1;
			by_s2  <= by_s1;
			cx_s2  <= $signed({side_s1.left, 1'b0}) + $signed({10'd0, side_s1.width});
			cy_s2  <= $signed({side_s1.top, 1'b0}) + $signed({10'd0, side_s1.height});
			d_s2   <= side_s1.orbit_dist;
			bad_s2 <= side_s1.bad;
		end
		if (en3) begin
			ux_s3  <= 72'(rz_s2 * by_s2);
			uya_s3 <= 72'(rx_s2 * bz_s2);
			uyb_s3 <= 72'(rz_s2 * bx_s2);
			uz_s3  <= 72'(rx_s2 * by_s2);
			ex_s3  <= 72'($signed({1'b0, d_s2}) * bx_s2);
			ey_s3  <= 72'($signed({1'b0, d_s2}) * by_s2);
			ez_s3  <= 72'($signed({1'b0, d_s2}) * bz_s2);
			rx_s3  <= 72'(rx_s2);
			rz_s3  <= 72'(rz_s2);
			bx_s3  <= 72'(bx_s2);
			by_s3  <= 72'(by_s2);
			bz_s3  <= 72'(bz_s2);
			cx_s3  <= cx_s2;
			cy_s3  <= cy_s2;
			bad_s3 <= bad_s2;
		end
		if (en4) begin
			if (bad_s3) begin
				right_x <= '0; right_z <= '0;
				up_x <= '0; up_y <= '0; up_z <= '0;
				back_x <= '0; back_y <= '0; back_z <= '0;
				eye_x <= '0; eye_y <= '0; eye_z <= '0;
				valid_res <= 1'b0;
			end else begin
				right_x <= unit_out(rx_s3);
				right_z <= unit_out(rz_s3);
				up_x <= unit_out(rnd30(ux_s3));
				up_y <= unit_out(rnd30(uya_s3 - uyb_s3));
				up_z <= unit_out(rnd30(-uz_s3));
				back_x <= unit_out(bx_s3);
				back_y <= unit_out(by_s3);
				back_z <= unit_out(bz_s3);
				eye_x <= eye_out((72'(cx_s3) <<< 29) + ex_s3);
				eye_y <= eye_out((72'(cy_s3) <<< 29) + ey_s3);
				eye_z <= eye_out(ez_s3);
				valid_res <= 1'b1;
			end
		end
	end
endmodule

### rtl/orbit_camera_look_at.sv
// top level of the orbit camera look-at pipeline
`timescale 1ns / 1ps
// usage
//   input channel: in_valid/in_ready with target rectangle, yaw, pitch, distance
//   output channel: out_valid/out_ready with right, up, back axes, eye, valid_res
//   one transaction in gives exactly one transaction out, in order
// stages: one angle reduction stage, one cordic stage per iteration, then
//   four product and rounding stages, each a register with its own valid bit
// throughput: one transaction per cycle while the output does not stall;
//   every stage is a register with its own valid bit, so a new transaction enters each cycle
// stall: when out_ready is low the result holds; empty stages further up
//   keep filling, so in_ready only drops once every stage holds a transaction
// reset: arst_n clears every valid bit, the pipeline is empty afterwards
// zero distance or vertical pitch gives valid_res low and all fields zero
module orbit_camera_look_at #(
	parameter int TRIG_STEPS = 16,
	parameter int UNIT_FRAC  = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] target_left,
	input  logic signed [31:0] target_top,
	input  logic [23:0]        target_width,
	input  logic [23:0]        target_height,
	input  logic signed [15:0] yaw_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic [23:0]        orbit_distance,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z,
	output logic signed [15:0] back_x,
	output logic signed [15:0] back_y,
	output logic signed [15:0] back_z,
	output logic signed [31:0] eye_x,
	output logic signed [31:0] eye_y,
	output logic signed [31:0] eye_z,
	output logic               valid_res
);
	import ocl_pkg::*;

	`include "orbit_camera_look_at_assert.svh"

	// stage 1: angle reduction and quadrant folding
	logic [14:0] ry, rp;
	logic        v_s1, en_s1, cord_ready;
	cord_t       cord_s1;
	trig_t       trig_d;
	logic        trig_valid, trig_ready;

	assign ry = reduce_angle(yaw_angle);
	assign rp = reduce_angle(pitch_angle);

	assign en_s1    = !v_s1 || cord_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cord_s1.yaw   <= fold_angle(ry);
			cord_s1.pitch <= fold_angle(rp);
			cord_s1.side.left   <= target_left;
			cord_s1.side.top    <= target_top;
			cord_s1.side.width  <= target_width;
			cord_s1.side.height <= target_height;
			cord_s1.side.orbit_dist <= orbit_distance;
			// pitch beyond a quarter turn flips the right axis
			cord_s1.side.right_neg <= !((rp < 15'(QUARTER_TURN)) ||
				(rp > 15'(FULL_TURN - QUARTER_TURN)));
			// no forward without distance, no right when looking straight up or down
			cord_s1.side.bad <= (orbit_distance == '0) || (rp == 15'(QUARTER_TURN)) ||
				(rp == 15'(FULL_TURN - QUARTER_TURN));
		end
	end

	ocl_cordic #(
		.STEPS(TRIG_STEPS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_ready (cord_ready),
		.in_data  (cord_s1),
		.out_valid(trig_valid),
		.out_ready(trig_ready),
		.out_data (trig_d)
	);

	ocl_vecmath #(
		.UNIT_FRAC(UNIT_FRAC)
	) u_vecmath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (trig_valid),
		.in_ready (trig_ready),
		.in_data  (trig_d),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.right_x  (right_x),
		.right_z  (right_z),
		.up_x     (up_x),
		.up_y     (up_y),
		.up_z     (up_z),
		.back_x   (back_x),
		.back_y   (back_y),
		.back_z   (back_z),
		.eye_x    (eye_x),
		.eye_y    (eye_y),
		.eye_z    (eye_z),
		.valid_res(valid_res)
	);

	// input side only blocks when the output is stalled
	`OCL_NEVER(a_stall_cause, !in_ready && !(out_valid && !out_ready))
	// an undefined matrix carries all-zero fields
	`OCL_ASSERT(a_bad_zero, (out_valid && !valid_res) |-> (right_x == '0 && eye_x == '0))
	// defined back axis stays on the unit scale
	`OCL_ASSERT(a_unit_range, (out_valid && valid_res) |-> (back_y <= 16'sd16384 && back_y >= -16'sd16384))
endmodule
